// ===== src/cidd_pkg.sv =====
package cidd_pkg;

    // result kinds
    localparam logic [1:0] KIND_COPY    = 2'd0;
    localparam logic [1:0] KIND_LITERAL = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error causes
    localparam logic [2:0] CAUSE_NONE        = 3'd0;
    localparam logic [2:0] CAUSE_SOURCE_SIZE = 3'd1;
    localparam logic [2:0] CAUSE_COPY_RANGE  = 3'd2;
    localparam logic [2:0] CAUSE_INS_OVERRUN = 3'd3;
    localparam logic [2:0] CAUSE_RESERVED_OP = 3'd4;
    localparam logic [2:0] CAUSE_FINAL_SIZE  = 3'd5;
    localparam logic [2:0] CAUSE_VARINT_LONG = 3'd6;

    // copy length that a zero length field stands for
    localparam logic [23:0] COPY_LEN_ZERO = 24'h010000;

    // result queue depth
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] copy_offset;
        logic [23:0] copy_length;
        logic [7:0]  literal_value;
        logic [31:0] write_position;
        logic [2:0]  error_cause;
        logic        final_result;
    } t_result;

    // results made by one accepted byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== src/cidd_intf.sv =====
// delta byte channel
interface cidd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] delta_byte;
    logic       stream_end;

    modport source (output valid, output delta_byte, output stream_end, input ready);
    modport sink (input valid, input delta_byte, input stream_end, output ready);
endinterface

// decoded result channel
interface cidd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] copy_offset;
    logic [23:0] copy_length;
    logic [7:0]  literal_value;
    logic [31:0] write_position;
    logic [2:0]  error_cause;
    logic        final_result;

    modport source (
        output valid, output result_kind, output copy_offset, output copy_length,
        output literal_value, output write_position, output error_cause,
        output final_result, input ready
    );
    modport sink (
        input valid, input result_kind, input copy_offset, input copy_length,
        input literal_value, input write_position, input error_cause,
        input final_result, output ready
    );
endinterface

// ===== src/copy_insert_delta_decoder.sv =====
// results are written into a four-entry result queue and offered from its head
// throughput: one delta byte per cycle while two queue entries are free; a byte
//   ending a stream can make two results, drained one per cycle while ready
// reset: synchronous, active low; clears stream state, base_length and the queue
module copy_insert_delta_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    cidd_byte_if.sink            i_delta,
    cidd_result_if.source        o_result
);

    localparam int QADDR_W = $clog2(cidd_pkg::QDEPTH);
    localparam int QCNT_W  = $clog2(cidd_pkg::QDEPTH + 1);

    logic [31:0]       r_base_length;
    cidd_pkg::t_result r_mem [cidd_pkg::QDEPTH];
    logic [QADDR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               in_fire;
    logic               out_fire;
    cidd_pkg::t_push    push;
    cidd_pkg::t_result  head;

    // base length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_base_length <= i_cfg_wr_data;
        end
    end

    // take a byte while the queue has room for two results
    assign i_delta.ready = (r_count <= QCNT_W'(cidd_pkg::QDEPTH - 2));
    assign in_fire       = i_delta.valid && i_delta.ready;
    assign out_fire      = o_result.valid && o_result.ready;

    cidd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_delta_byte  (i_delta.delta_byte),
        .i_stream_end  (i_delta.stream_end),
        .i_base_length (r_base_length),
        .o_push        (push)
    );

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= push.first;
        end
        if (push.count == 2'd2) begin
            r_mem[r_wr_ptr + QADDR_W'(1)] <= push.second;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QADDR_W'(push.count);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + QADDR_W'(1);
            end
            r_count <= r_count + QCNT_W'(push.count) - QCNT_W'(out_fire);
        end
    end

    // queue head drives the result transaction
    assign head                    = r_mem[r_rd_ptr];
    assign o_result.valid          = (r_count != '0);
    assign o_result.result_kind    = head.result_kind;
    assign o_result.copy_offset    = head.copy_offset;
    assign o_result.copy_length    = head.copy_length;
    assign o_result.literal_value  = head.literal_value;
    assign o_result.write_position = head.write_position;
    assign o_result.error_cause    = head.error_cause;
    assign o_result.final_result   = head.final_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(cidd_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> in_fire)
        else $error("result pushed without an input transaction");

    a_pair_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (i_delta.stream_end && push.second.final_result))
        else $error("two results from a byte that does not end the stream");
`endif

endmodule

// ===== src/cidd_core.sv =====
module cidd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_delta_byte,
    input  logic                i_stream_end,
    input  logic [31:0]         i_base_length,
    output cidd_pkg::t_push     o_push
);

    typedef enum logic [2:0] {
        PH_SRC,
        PH_DST,
        PH_OP,
        PH_ARGS,
        PH_INS
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_src_acc, n_src_acc;
    logic [31:0] r_res_size, n_res_size;
    logic [2:0]  r_shift, n_shift;
    logic [31:0] r_out_pos, n_out_pos;
    logic [6:0]  r_mask, n_mask;
    logic [31:0] r_pend_off, n_pend_off;
    logic [23:0] r_pend_len, n_pend_len;
    logic [6:0]  r_lits, n_lits;
    logic        r_err, n_err;

    logic [31:0] v_in, v_acc;
    logic [2:0]  v_shift;
    logic        v_bad;
    logic [2:0]  arg_k;
    logic [31:0] arg_off;
    logic [23:0] arg_len;
    logic [6:0]  arg_mask;
    logic [31:0] c_off;
    logic [23:0] c_len;
    logic [23:0] len_eff;
    logic        copy_bad;
    logic        ins_bad;
    logic        do_copy;
    logic        do_clear;
    logic        err_hit;
    logic [2:0]  err_cause;
    logic        has_main;
    cidd_pkg::t_result res_main;
    cidd_pkg::t_result res_end;
    logic        has_end;

    // varint byte merge for the two size headers
    always_comb begin
        v_in    = (r_phase == PH_SRC) ? r_src_acc : r_res_size;
        v_acc   = v_in;
        v_shift = r_shift;
        v_bad   = 1'b0;
        if (r_shift >= 3'd4) begin
            v_bad = |i_delta_byte[7:4];
            v_acc = v_in | {i_delta_byte[3:0], 28'd0};
        end else begin
            unique case (r_shift[1:0])
                2'd0: v_acc = v_in | {25'd0, i_delta_byte[6:0]};
                2'd1: v_acc = v_in | {18'd0, i_delta_byte[6:0], 7'd0};
                2'd2: v_acc = v_in | {11'd0, i_delta_byte[6:0], 14'd0};
                2'd3: v_acc = v_in | {4'd0, i_delta_byte[6:0], 21'd0};
                default: v_acc = v_in;
            endcase
            if (i_delta_byte[7]) begin
                v_shift = r_shift + 3'd1;
            end
        end
    end

    // copy argument byte placement, lowest selected field first
    always_comb begin
        priority if (r_mask[0]) begin
            arg_k = 3'd0;
        end else if (r_mask[1]) begin
            arg_k = 3'd1;
        end else if (r_mask[2]) begin
            arg_k = 3'd2;
        end else if (r_mask[3]) begin
            arg_k = 3'd3;
        end else if (r_mask[4]) begin
            arg_k = 3'd4;
        end else if (r_mask[5]) begin
            arg_k = 3'd5;
        end else begin
            arg_k = 3'd6;
        end
        arg_off = r_pend_off;
        arg_len = r_pend_len;
        unique case (arg_k)
            3'd0: arg_off[7:0]   = r_pend_off[7:0] | i_delta_byte;
            3'd1: arg_off[15:8]  = r_pend_off[15:8] | i_delta_byte;
            3'd2: arg_off[23:16] = r_pend_off[23:16] | i_delta_byte;
            3'd3: arg_off[31:24] = r_pend_off[31:24] | i_delta_byte;
            3'd4: arg_len[7:0]   = r_pend_len[7:0] | i_delta_byte;
            3'd5: arg_len[15:8]  = r_pend_len[15:8] | i_delta_byte;
            3'd6: arg_len[23:16] = r_pend_len[23:16] | i_delta_byte;
            default: arg_off = r_pend_off;
        endcase
        arg_mask = r_mask & (r_mask - 7'd1);
    end

    // range checks for copy and insert
    always_comb begin
        c_off    = (r_phase == PH_ARGS) ? arg_off : 32'd0;
        c_len    = (r_phase == PH_ARGS) ? arg_len : 24'd0;
        len_eff  = (c_len == 24'd0) ? cidd_pkg::COPY_LEN_ZERO : c_len;
        copy_bad = (({1'b0, c_off} + {9'd0, len_eff}) > {1'b0, i_base_length}) ||
                   (({1'b0, r_out_pos} + {9'd0, len_eff}) > {1'b0, r_res_size});
        ins_bad  = ({1'b0, r_out_pos} + {26'd0, i_delta_byte[6:0]}) > {1'b0, r_res_size};
    end

    // per-byte decode and next state
    always_comb begin
        n_phase    = r_phase;
        n_src_acc  = r_src_acc;
        n_res_size = r_res_size;
        n_shift    = r_shift;
        n_out_pos  = r_out_pos;
        n_mask     = r_mask;
        n_pend_off = r_pend_off;
        n_pend_len = r_pend_len;
        n_lits     = r_lits;
        n_err      = r_err;
        do_copy    = 1'b0;
        do_clear   = 1'b0;
        err_hit    = 1'b0;
        err_cause  = cidd_pkg::CAUSE_NONE;
        has_main   = 1'b0;
        has_end    = 1'b0;
        res_main   = '0;
        res_end    = '0;

        if (i_fire) begin
            if (r_err) begin
                do_clear = i_stream_end;
            end else begin
                unique case (r_phase)
                    PH_SRC: begin
                        if (v_bad) begin
                            err_hit   = 1'b1;
                            err_cause = cidd_pkg::CAUSE_VARINT_LONG;
                        end else begin
                            n_src_acc = v_acc;
                            n_shift   = v_shift;
                            if (!i_delta_byte[7] || i_stream_end) begin
                                if (v_acc != i_base_length) begin
                                    err_hit   = 1'b1;
                                    err_cause = cidd_pkg::CAUSE_SOURCE_SIZE;
                                end else begin
                                    n_phase = PH_DST;
                                    n_shift = 3'd0;
                                end
                            end
                        end
                    end
                    PH_DST: begin
                        if (v_bad) begin
                            err_hit   = 1'b1;
                            err_cause = cidd_pkg::CAUSE_VARINT_LONG;
                        end else begin
                            n_res_size = v_acc;
                            n_shift    = v_shift;
                            if (!i_delta_byte[7]) begin
                                n_phase = PH_OP;
                                n_shift = 3'd0;
                            end
                        end
                    end
                    PH_OP: begin
                        if (i_delta_byte[7]) begin
                            n_mask     = i_delta_byte[6:0];
                            n_pend_off = 32'd0;
                            n_pend_len = 24'd0;
                            if ((i_delta_byte[6:0] == 7'd0) || i_stream_end) begin
                                do_copy = 1'b1;
                            end else begin
                                n_phase = PH_ARGS;
                            end
                        end else if (i_delta_byte != 8'd0) begin
                            if (i_stream_end || ins_bad) begin
                                err_hit   = 1'b1;
                                err_cause = cidd_pkg::CAUSE_INS_OVERRUN;
                            end else begin
                                n_lits  = i_delta_byte[6:0];
                                n_phase = PH_INS;
                            end
                        end else begin
                            err_hit   = 1'b1;
                            err_cause = cidd_pkg::CAUSE_RESERVED_OP;
                        end
                    end
                    PH_ARGS: begin
                        n_mask     = arg_mask;
                        n_pend_off = arg_off;
                        n_pend_len = arg_len;
                        if ((arg_mask == 7'd0) || i_stream_end) begin
                            do_copy = 1'b1;
                        end
                    end
                    PH_INS: begin
                        if (i_stream_end && (r_lits > 7'd1)) begin
                            err_hit   = 1'b1;
                            err_cause = cidd_pkg::CAUSE_INS_OVERRUN;
                        end else begin
                            has_main                = 1'b1;
                            res_main.result_kind    = cidd_pkg::KIND_LITERAL;
                            res_main.literal_value  = i_delta_byte;
                            res_main.write_position = r_out_pos;
                            n_out_pos               = r_out_pos + 32'd1;
                            n_lits                  = r_lits - 7'd1;
                            if (r_lits == 7'd1) begin
                                n_phase = PH_OP;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SRC;
                    end
                endcase

                // issue a finished copy command
                if (do_copy) begin
                    if (copy_bad) begin
                        err_hit   = 1'b1;
                        err_cause = cidd_pkg::CAUSE_COPY_RANGE;
                    end else begin
                        has_main                = 1'b1;
                        res_main.result_kind    = cidd_pkg::KIND_COPY;
                        res_main.copy_offset    = c_off;
                        res_main.copy_length    = len_eff;
                        res_main.write_position = r_out_pos;
                        n_out_pos               = r_out_pos + {8'd0, len_eff};
                        n_mask                  = 7'd0;
                        n_pend_off              = 32'd0;
                        n_pend_len              = 24'd0;
                        n_phase                 = PH_OP;
                    end
                end

                // error result, or final size check at stream end
                if (err_hit) begin
                    has_main                = 1'b1;
                    res_main                = '0;
                    res_main.result_kind    = cidd_pkg::KIND_ERROR;
                    res_main.write_position = r_out_pos;
                    res_main.error_cause    = err_cause;
                    res_main.final_result   = 1'b1;
                    do_clear                = i_stream_end;
                    n_err                   = !i_stream_end;
                end else if (i_stream_end) begin
                    has_end              = 1'b1;
                    res_end.final_result = 1'b1;
                    if (n_out_pos != n_res_size) begin
                        res_end.result_kind    = cidd_pkg::KIND_ERROR;
                        res_end.write_position = n_out_pos;
                        res_end.error_cause    = cidd_pkg::CAUSE_FINAL_SIZE;
                    end else begin
                        res_end.result_kind    = cidd_pkg::KIND_DONE;
                        res_end.write_position = n_res_size;
                    end
                    do_clear = 1'b1;
                end
            end
        end

        // stream end returns the per-stream state to reset values
        if (do_clear) begin
            n_phase    = PH_SRC;
            n_src_acc  = 32'd0;
            n_res_size = 32'd0;
            n_shift    = 3'd0;
            n_out_pos  = 32'd0;
            n_mask     = 7'd0;
            n_pend_off = 32'd0;
            n_pend_len = 24'd0;
            n_lits     = 7'd0;
            n_err      = 1'b0;
        end
    end

    // results in delivery order
    always_comb begin
        o_push.count  = {1'b0, has_main} + {1'b0, has_end};
        o_push.first  = has_main ? res_main : res_end;
        o_push.second = res_end;
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SRC;
            r_src_acc  <= 32'd0;
            r_res_size <= 32'd0;
            r_shift    <= 3'd0;
            r_out_pos  <= 32'd0;
            r_mask     <= 7'd0;
            r_pend_off <= 32'd0;
            r_pend_len <= 24'd0;
            r_lits     <= 7'd0;
            r_err      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_src_acc  <= n_src_acc;
            r_res_size <= n_res_size;
            r_shift    <= n_shift;
            r_out_pos  <= n_out_pos;
            r_mask     <= n_mask;
            r_pend_off <= n_pend_off;
            r_pend_len <= n_pend_len;
            r_lits     <= n_lits;
            r_err      <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift <= 3'd4)
        else $error("varint byte count out of range");

    // a copy range error leaves the phase as is with the mask already used up
    a_args_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_ARGS) && !r_err) |-> (r_mask != 7'd0))
        else $error("copy argument phase with empty mask");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INS) |-> (r_lits != 7'd0))
        else $error("insert phase with no literals left");
`endif

endmodule

// ===== dv/cidd_delta_checker.sv =====
module cidd_delta_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    cidd_byte_if        delta,
    cidd_result_if      result,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_seen,
    output int          o_copy_count,
    output int          o_literal_count,
    output int          o_done_count,
    output int          o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import cidd_pkg::*;

    typedef enum logic [2:0] {
        ST_SOURCE_SIZE,
        ST_RESULT_SIZE,
        ST_OPCODE,
        ST_COPY_ARGS,
        ST_INSERT
    } t_parse_state;

    // decoder state as predicted from the accepted bytes
    t_parse_state parse_state;
    logic [31:0]  base_len;
    logic [31:0]  source_len;
    logic [31:0]  target_len;
    logic [2:0]   group_count;
    logic [31:0]  out_pos;
    logic [6:0]   arg_mask;
    logic [31:0]  copy_off;
    logic [23:0]  copy_len;
    logic [6:0]   lits_left;
    logic         err_latched;

    t_result      expected_results[$];

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic string show(t_result r);
        return $sformatf("kind %0d off %h len %h lit %h pos %h cause %0d last %0b",
                         r.result_kind, r.copy_offset, r.copy_length, r.literal_value,
                         r.write_position, r.error_cause, r.final_result);
    endfunction

    function automatic void clear_stream();
        parse_state = ST_SOURCE_SIZE;
        source_len  = '0;
        target_len  = '0;
        group_count = '0;
        out_pos     = '0;
        arg_mask    = '0;
        copy_off    = '0;
        copy_len    = '0;
        lits_left   = '0;
        err_latched = 1'b0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [31:0] off, logic [23:0] len,
                                        logic [7:0] lit, logic [31:0] pos, logic [2:0] cause,
                                        logic fin);
        t_result r;
        r.result_kind    = kind;
        r.copy_offset    = off;
        r.copy_length    = len;
        r.literal_value  = lit;
        r.write_position = pos;
        r.error_cause    = cause;
        r.final_result   = fin;
        expected_results.push_back(r);
    endfunction

    // error result; stream state clears now on the last byte, else at the stream end
    function automatic void raise_error(logic [2:0] cause, logic last);
        push_result(KIND_ERROR, '0, '0, '0, out_pos, cause, 1'b1);
        if (last)
            clear_stream();
        else
            err_latched = 1'b1;
    endfunction

    // one size byte, low group first; 0 when the size no longer fits 32 bits
    function automatic bit add_size_group(logic [7:0] b, inout logic [31:0] acc);
        if (group_count >= 3'd4) begin
            if (b[7:4] != 4'd0)
                return 1'b0;
            acc[31:28] = acc[31:28] | b[3:0];
            return 1'b1;
        end
        acc = acc | (32'(b[6:0]) << (7 * group_count));
        if (b[7])
            group_count = group_count + 3'd1;
        return 1'b1;
    endfunction

    // copy command from the collected arguments; 0 when it leaves either buffer
    function automatic bit issue_copy();
        logic [32:0] len;
        len = (copy_len != '0) ? {9'd0, copy_len} : {9'd0, COPY_LEN_ZERO};
        if ({1'b0, copy_off} + len > {1'b0, base_len} ||
            {1'b0, out_pos} + len > {1'b0, target_len})
            return 1'b0;
        push_result(KIND_COPY, copy_off, len[23:0], '0, out_pos, CAUSE_NONE, 1'b0);
        out_pos     = out_pos + len[31:0];
        arg_mask    = '0;
        copy_off    = '0;
        copy_len    = '0;
        parse_state = ST_OPCODE;
        return 1'b1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        int k;
        // after an error everything up to the stream end is dropped
        if (err_latched) begin
            if (last)
                clear_stream();
            return;
        end
        case (parse_state)
            ST_SOURCE_SIZE: begin
                if (!add_size_group(b, source_len)) begin
                    raise_error(CAUSE_VARINT_LONG, last);
                    return;
                end
                if (!b[7] || last) begin
                    if (source_len != base_len) begin
                        raise_error(CAUSE_SOURCE_SIZE, last);
                        return;
                    end
                    parse_state = ST_RESULT_SIZE;
                    group_count = '0;
                end
            end
            ST_RESULT_SIZE: begin
                if (!add_size_group(b, target_len)) begin
                    raise_error(CAUSE_VARINT_LONG, last);
                    return;
                end
                if (!b[7]) begin
                    parse_state = ST_OPCODE;
                    group_count = '0;
                end
            end
            ST_OPCODE: begin
                if (b[7]) begin
                    arg_mask = b[6:0];
                    copy_off = '0;
                    copy_len = '0;
                    if (arg_mask == '0 || last) begin
                        if (!issue_copy()) begin
                            raise_error(CAUSE_COPY_RANGE, last);
                            return;
                        end
                    end else begin
                        parse_state = ST_COPY_ARGS;
                    end
                end else if (b != 8'd0) begin
                    if (last || {1'b0, out_pos} + {25'd0, b} > {1'b0, target_len}) begin
                        raise_error(CAUSE_INS_OVERRUN, last);
                        return;
                    end
                    lits_left   = b[6:0];
                    parse_state = ST_INSERT;
                end else begin
                    raise_error(CAUSE_RESERVED_OP, last);
                    return;
                end
            end
            ST_COPY_ARGS: begin
                // argument bytes fill the lowest selected slot first
                k = 0;
                while (k < 6 && !arg_mask[k])
                    k++;
                if (k < 4)
                    copy_off = copy_off | (32'(b) << (8 * k));
                else
                    copy_len = copy_len | (24'(b) << (8 * (k - 4)));
                arg_mask = arg_mask & (arg_mask - 7'd1);
                if (arg_mask == '0 || last) begin
                    if (!issue_copy()) begin
                        raise_error(CAUSE_COPY_RANGE, last);
                        return;
                    end
                end
            end
            default: begin
                if (last && lits_left > 7'd1) begin
                    raise_error(CAUSE_INS_OVERRUN, last);
                    return;
                end
                push_result(KIND_LITERAL, '0, '0, b, out_pos, CAUSE_NONE, 1'b0);
                out_pos   = out_pos + 32'd1;
                lits_left = lits_left - 7'd1;
                if (lits_left == '0)
                    parse_state = ST_OPCODE;
            end
        endcase
        // final size check on the stream end
        if (last) begin
            if (out_pos != target_len)
                push_result(KIND_ERROR, '0, '0, '0, out_pos, CAUSE_FINAL_SIZE, 1'b1);
            else
                push_result(KIND_DONE, '0, '0, '0, target_len, CAUSE_NONE, 1'b1);
            clear_stream();
        end
    endfunction

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            base_len = '0;
            clear_stream();
            expected_results.delete();
            o_fail_count    = 0;
            o_bytes_seen    = 0;
            o_copy_count    = 0;
            o_literal_count = 0;
            o_done_count    = 0;
            o_error_count   = 0;
        end else begin
            if (i_cfg_wr_en)
                base_len = i_cfg_wr_data;
            // result transaction against the oldest expectation
            if (result.valid && result.ready) begin
                got.result_kind    = result.result_kind;
                got.copy_offset    = result.copy_offset;
                got.copy_length    = result.copy_length;
                got.literal_value  = result.literal_value;
                got.write_position = result.write_position;
                got.error_cause    = result.error_cause;
                got.final_result   = result.final_result;
                case (got.result_kind)
                    KIND_COPY:    o_copy_count++;
                    KIND_LITERAL: o_literal_count++;
                    KIND_DONE:    o_done_count++;
                    default:      o_error_count++;
                endcase
                if (expected_results.size() == 0) begin
                    report_mismatch({"unexpected result: ", show(got)});
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch({"got ", show(got), " expected ", show(want)});
                end
            end
            // byte transaction feeds the predictor
            if (delta.valid && delta.ready) begin
                decode_byte(delta.delta_byte, delta.stream_end);
                o_bytes_seen++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cidd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    cidd_byte_if   delta_ch ();
    cidd_result_if result_ch ();

    int fail_count;
    int results_pending;
    int bytes_seen;
    int copy_count;
    int literal_count;
    int done_count;
    int error_count;

    copy_insert_delta_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_delta       (delta_ch),
        .o_result      (result_ch)
    );

    cidd_delta_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .delta           (delta_ch),
        .result          (result_ch),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending),
        .o_bytes_seen    (bytes_seen),
        .o_copy_count    (copy_count),
        .o_literal_count (literal_count),
        .o_done_count    (done_count),
        .o_error_count   (error_count)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    logic [8:0]  byte_queue[$];     // {stream_end, delta_byte} waiting to be sent
    logic [7:0]  delta_stream[$];   // delta under construction
    logic [7:0]  op_stream[$];      // opcodes and their bytes, before the header
    logic [31:0] base_plan[9];
    int          bytes_pushed;
    int          streams_sent;
    bit          byte_taken;
    bit          steady;
    bit          hold_request;
    bit          hold_active;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // byte transaction seen at the rising edge
    always @(posedge i_clk)
        byte_taken <= delta_ch.valid && delta_ch.ready;

    // byte sender
    initial begin
        logic [8:0] item;
        int         send_gap;
        delta_ch.valid      <= 1'b0;
        delta_ch.delta_byte <= '0;
        delta_ch.stream_end <= 1'b0;
        send_gap = 0;
        forever begin
            @(negedge i_clk);
            if (!delta_ch.valid || byte_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    delta_ch.valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    item = byte_queue.pop_front();
                    delta_ch.delta_byte <= item[7:0];
                    delta_ch.stream_end <= item[8];
                    delta_ch.valid      <= 1'b1;
                    send_gap = steady ? 0 : pick_gap();
                end else begin
                    delta_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls
    initial begin
        int stall_left;
        result_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_active || stall_left > 0) begin
                result_ch.ready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the result queue fills and input backs up
    initial begin
        hold_active <= 1'b0;
        wait (hold_request);
        @(negedge i_clk);
        hold_active <= 1'b1;
        repeat (300) @(negedge i_clk);
        hold_active <= 1'b0;
    end

    // run limit
    initial begin
        #20000000;
        $display("timeout: decoder stopped making progress");
        $display("copy_insert_delta_decoder test failed");
        $finish;
    end

    // wait for every byte and result, then let the pipeline drain
    task automatic settle();
        do @(negedge i_clk);
        while (bytes_seen != bytes_pushed || results_pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_base(logic [31:0] value);
        settle();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // hand the built delta to the sender; the last byte ends the stream
    task automatic queue_stream();
        bit last;
        do @(posedge i_clk);
        while (byte_queue.size() >= 16);
        foreach (delta_stream[i]) begin
            last = (i == delta_stream.size() - 1);
            byte_queue.push_back({last, delta_stream[i]});
        end
        bytes_pushed += delta_stream.size();
        streams_sent++;
    endtask

    // size varint, optionally padded with zero groups up to five bytes
    function automatic void put_size(logic [31:0] value, bit pad);
        logic [31:0] rest;
        logic [7:0]  b;
        int          groups;
        int          pad_left;
        rest     = value;
        groups   = 0;
        pad_left = pad ? $urandom_range(1, 4) : 0;
        forever begin
            b      = {1'b0, rest[6:0]};
            rest   = rest >> 7;
            groups++;
            if (rest == '0 && (groups >= 5 || pad_left == 0)) begin
                delta_stream.push_back(b);
                break;
            end
            if (rest == '0)
                pad_left--;
            delta_stream.push_back(b | 8'h80);
        end
    endfunction

    // five-byte varint whose last byte overflows 32 bits
    function automatic void put_long_size();
        repeat (4) delta_stream.push_back(8'h80 | 8'($urandom_range(0, 127)));
        delta_stream.push_back(8'($urandom_range(16, 255)));
    endfunction

    function automatic void put_insert(inout logic [31:0] produced);
        int r;
        int count;
        r = $urandom_range(0, 99);
        if (r < 80)
            count = $urandom_range(1, 8);
        else if (r < 95)
            count = $urandom_range(9, 40);
        else
            count = $urandom_range(41, 127);
        op_stream.push_back(8'(count));
        repeat (count) op_stream.push_back(8'($urandom));
        produced = produced + 32'(count);
    endfunction

    // copy inside the base, now and then one that reaches just past its end
    function automatic void put_copy(logic [31:0] base, inout logic [31:0] produced);
        logic [63:0] cap;
        logic [63:0] span;
        logic [31:0] len;
        logic [31:0] off;
        logic [6:0]  mask;
        logic [7:0]  args[$];
        bit          zero_len;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8 && base >= 32'h10000) begin
            len = 32'h10000;
        end else begin
            cap = (r < 14) ? 64'hFF_FFFF : 64'd300;
            if (64'(base) < cap)
                cap = 64'(base);
            len = 32'(1 + 64'($urandom) % cap);
        end
        span = 64'(base) - 64'(len) + 64'd1;
        r = $urandom_range(0, 99);
        if (r < 3)
            off = 32'(span);
        else if (r < 13)
            off = 32'(span - 64'd1);
        else if (r < 20)
            off = '0;
        else
            off = 32'(64'($urandom) % span);
        // offset bytes, then length bytes; zero bytes are sometimes sent anyway
        mask     = '0;
        zero_len = (len == 32'h10000) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < 4; i++) begin
            if (off[8*i +: 8] != 8'd0 || $urandom_range(0, 7) == 0) begin
                mask[i] = 1'b1;
                args.push_back(off[8*i +: 8]);
            end
        end
        if (!zero_len) begin
            for (int i = 0; i < 3; i++) begin
                if (len[8*i +: 8] != 8'd0 || $urandom_range(0, 7) == 0) begin
                    mask[4+i] = 1'b1;
                    args.push_back(len[8*i +: 8]);
                end
            end
        end
        op_stream.push_back({1'b1, mask});
        foreach (args[i]) op_stream.push_back(args[i]);
        produced = produced + len;
    endfunction

    // mostly well-formed deltas, the rest noise or damaged in one way
    task automatic build_delta(logic [31:0] base);
        int          shape;
        int          cut;
        int          pos;
        logic [31:0] produced;
        logic [31:0] src;
        logic [31:0] dst;
        delta_stream.delete();
        op_stream.delete();
        shape = $urandom_range(0, 99);
        if (shape < 5) begin
            repeat ($urandom_range(1, 10)) delta_stream.push_back(8'($urandom));
            return;
        end
        if (shape < 9) begin
            if (shape >= 7)
                put_size(base, 1'b0);
            put_long_size();
            repeat ($urandom_range(0, 3)) delta_stream.push_back(8'($urandom));
            return;
        end
        produced = '0;
        repeat ($urandom_range(0, 5)) begin
            if (base != '0 && $urandom_range(0, 1) == 1)
                put_copy(base, produced);
            else
                put_insert(produced);
        end
        dst = produced;
        if (shape < 15)
            dst = ($urandom_range(0, 1) == 1) ? dst + $urandom_range(1, 3)
                                              : dst - $urandom_range(1, 3);
        src = (shape >= 15 && shape < 19) ? base ^ (32'd1 << $urandom_range(0, 31)) : base;
        put_size(src, $urandom_range(0, 4) == 0);
        put_size(dst, $urandom_range(0, 4) == 0);
        foreach (op_stream[i]) delta_stream.push_back(op_stream[i]);
        if (shape >= 19 && shape < 26) begin
            cut = $urandom_range(1, delta_stream.size());
            while (delta_stream.size() > cut)
                void'(delta_stream.pop_back());
        end else if (shape >= 26 && shape < 30) begin
            pos = $urandom_range(0, delta_stream.size() - 1);
            delta_stream[pos] = delta_stream[pos] ^ (8'd1 << $urandom_range(0, 7));
        end else if (shape >= 30 && shape < 32) begin
            delta_stream.insert($urandom_range(0, delta_stream.size()), 8'h00);
        end
    endtask

    // stimulus and verdict
    initial begin
        int phase_start;
        i_rst_n     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed deltas against the reset base length of zero
        delta_stream = '{8'h05};                                  // source size wrong at end
        queue_stream();
        delta_stream = '{8'h00, 8'h05, 8'h00, 8'hFF};             // reserved opcode
        queue_stream();
        delta_stream = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00}; // varint too long
        queue_stream();
        delta_stream = '{8'h00, 8'h02, 8'h02, 8'h41, 8'h42};      // literals then done
        queue_stream();
        delta_stream = '{8'h00, 8'h01, 8'h02, 8'h00};             // insert past result size
        queue_stream();
        delta_stream = '{8'h00, 8'h03, 8'h03, 8'hAA};             // stream ends inside insert
        queue_stream();

        // cut-off copy: offset byte arrives, length reads as zero, range fails
        write_base(32'h0002_0000);
        delta_stream = '{8'h80, 8'h80, 8'h08, 8'h05, 8'h91, 8'h10};
        queue_stream();

        base_plan = '{32'hFFFF_FFFF, 32'd0, $urandom, 32'd1, 32'h8000_0000,
                      $urandom_range(2, 400), 32'h0001_0000, $urandom, 32'd300};

        // random deltas, one base length per phase
        for (int p = 0; p < 9; p++) begin
            write_base(base_plan[p]);
            steady = (p == 4 || p == 7);
            if (p == 2)
                hold_request = 1'b1;
            phase_start = bytes_pushed;
            while (bytes_pushed - phase_start < 195) begin
                build_delta(base_plan[p]);
                queue_stream();
            end
        end

        settle();
        $display("sent %0d delta bytes in %0d streams under 11 base_length settings",
                 bytes_pushed, streams_sent);
        $display("checked %0d copies, %0d literals, %0d done, %0d errors",
                 copy_count, literal_count, done_count, error_count);
        if (fail_count == 0 && results_pending == 0)
            $display("copy_insert_delta_decoder test passed");
        else
            $display("copy_insert_delta_decoder test failed");
        $finish;
    end

endmodule

// ===== copy_insert_delta_decoder.f =====
src/cidd_pkg.sv
src/cidd_intf.sv
src/cidd_core.sv
src/copy_insert_delta_decoder.sv
dv/cidd_delta_checker.sv
dv/testbench.sv
